/* hdl/bbmm_pkg.sv */
`timescale 1ns / 1ps

package bbmm_pkg;

    // reduction length and the widths that follow from it
    localparam int MAX_IN = 1024;
    localparam int CNT_W  = $clog2(MAX_IN + 1);
    localparam int POS_W  = $clog2(MAX_IN);

    // fixed field widths
    localparam int IDX_W  = 10;
    localparam int X_W    = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 42;
    localparam int Y_W    = 42;
    localparam int BETA_W = 16;
    localparam int FRAC_W = 15;

    // apb port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int RIDX_W = ADDR_W - 2;

    localparam logic [RIDX_W-1:0] REG_BETA = RIDX_W'(0);

    localparam logic [BETA_W-1:0] Q15_ONE = BETA_W'(32768);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic [X_W-1:0] x_value;
        logic [X_W-1:0] w_value;
        logic           last_element;
    } t_in_item;

    typedef struct packed {
        logic [Y_W-1:0]   y_value;
        logic [IDX_W-1:0] max_index;
        logic [IDX_W-1:0] min_index;
        logic             overflow;
    } t_out_item;

    // finished reduction handed from the accumulator to the blend pipeline
    typedef struct packed {
        logic [ACC_W-1:0]  sum;
        logic [PROD_W-1:0] max_prod;
        logic [PROD_W-1:0] min_prod;
        logic [POS_W-1:0]  max_pos;
        logic [POS_W-1:0]  min_pos;
        logic              ovf;
    } t_snap;

    // position to the low bits of an index field
    function automatic logic [IDX_W-1:0] f_idx(input logic [POS_W-1:0] pos);
        logic [POS_W+IDX_W-1:0] ext;
        ext = {{IDX_W{1'b0}}, pos};
        return ext[IDX_W-1:0];
    endfunction

endpackage

/* hdl/bbmm_if.sv */
`timescale 1ns / 1ps

interface bbmm_in_if ();
    import bbmm_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bbmm_out_if ();
    import bbmm_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hdl/bbmm_apb_regs.sv */
`timescale 1ns / 1ps

module bbmm_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bbmm_pkg::ADDR_W-1:0]   paddr,
    input  logic [bbmm_pkg::DATA_W-1:0]   pwdata,
    output logic [bbmm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [bbmm_pkg::BETA_W-1:0]   o_beta
);
    import bbmm_pkg::*;

    logic [BETA_W-1:0] r_beta;
    logic [RIDX_W-1:0] reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta <= Q15_ONE;
        end else if (wr_en && (reg_idx == REG_BETA)) begin
            r_beta <= pwdata[BETA_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_BETA) begin
            prdata = {{(DATA_W-BETA_W){1'b0}}, r_beta};
        end
    end

    assign o_beta = r_beta;

endmodule

/* hdl/bbmm_accum.sv */
`timescale 1ns / 1ps

module bbmm_accum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bbmm_in_if.sink         i_in,
    output logic            o_snap_valid,
    input  logic            i_snap_ready,
    output bbmm_pkg::t_snap o_snap
);
    import bbmm_pkg::*;

    // input register
    logic     r_in_valid;
    t_in_item r_in;

    // product register
    logic                     r_p_valid;
    logic                     r_p_last;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    // running reduction
    logic [CNT_W-1:0]         r_count;
    logic                     r_ovf;
    logic signed [ACC_W-1:0]  r_sum;
    logic signed [PROD_W-1:0] r_max;
    logic signed [PROD_W-1:0] r_min;
    logic [POS_W-1:0]         r_max_pos;
    logic [POS_W-1:0]         r_min_pos;

    logic [CNT_W-1:0]         n_count;
    logic                     n_ovf;
    logic signed [ACC_W-1:0]  n_sum;
    logic signed [PROD_W-1:0] n_max;
    logic signed [PROD_W-1:0] n_min;
    logic [POS_W-1:0]         n_max_pos;
    logic [POS_W-1:0]         n_min_pos;
    logic [POS_W-1:0]         pos;
    logic signed [ACC_W:0]    sum_wide;

    logic   r_snap_valid;
    t_snap  r_snap;

    logic in_ready;
    logic p_ready;
    logic consume;

    assign consume  = r_p_valid && (!r_p_last || !r_snap_valid || i_snap_ready);
    assign p_ready  = !r_p_valid || consume;
    assign in_ready = !r_in_valid || p_ready;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in <= i_in.payload;
        end
    end

    assign n_prod = $signed(r_in.x_value) * $signed(r_in.w_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (p_ready) begin
            r_p_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_ready && r_in_valid) begin
            r_prod   <= n_prod;
            r_p_last <= r_in.last_element;
        end
    end

    // position, compare and saturating add for the pair in the product register
    always_comb begin
        if (r_count >= CNT_W'(MAX_IN)) begin
            n_ovf   = 1'b1;
            pos     = POS_W'(MAX_IN - 1);
            n_count = r_count;
        end else begin
            n_ovf   = r_ovf;
            pos     = r_count[POS_W-1:0];
            n_count = r_count + 1'b1;
        end

        n_max     = r_max;
        n_min     = r_min;
        n_max_pos = r_max_pos;
        n_min_pos = r_min_pos;
        if (r_count == '0) begin
            n_max     = r_prod;
            n_min     = r_prod;
            n_max_pos = '0;
            n_min_pos = '0;
        end else begin
            if (r_prod > r_max) begin
                n_max     = r_prod;
                n_max_pos = pos;
            end
            if (r_prod < r_min) begin
                n_min     = r_prod;
                n_min_pos = pos;
            end
        end

        sum_wide = (ACC_W+1)'(r_sum) + (ACC_W+1)'(r_prod);
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
            n_sum = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            n_sum = sum_wide[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_sum   <= '0;
        end else if (consume) begin
            if (r_p_last) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_sum   <= '0;
            end else begin
                r_count <= n_count;
                r_ovf   <= n_ovf;
                r_sum   <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume) begin
            r_max     <= n_max;
            r_min     <= n_min;
            r_max_pos <= n_max_pos;
            r_min_pos <= n_min_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (consume && r_p_last) begin
            r_snap_valid <= 1'b1;
        end else if (i_snap_ready) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && r_p_last) begin
            r_snap.sum      <= n_sum;
            r_snap.max_prod <= n_max;
            r_snap.min_prod <= n_min;
            r_snap.max_pos  <= n_max_pos;
            r_snap.min_pos  <= n_min_pos;
            r_snap.ovf      <= n_ovf;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule

/* hdl/bbmm_blend.sv */
`timescale 1ns / 1ps

module bbmm_blend (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_snap_valid,
    output logic                        o_snap_ready,
    input  bbmm_pkg::t_snap             i_snap,
    input  logic [bbmm_pkg::BETA_W-1:0] i_beta,
    bbmm_out_if.source                  o_out
);
    import bbmm_pkg::*;

    localparam int LO_W  = ACC_W / 2;
    localparam int HI_W  = ACC_W - LO_W;
    localparam int CF_W  = BETA_W + 1;
    localparam int MM_W  = PROD_W + 1;
    localparam int PHI_W = HI_W + CF_W;
    localparam int PLO_W = LO_W + 1 + CF_W;
    localparam int PMM_W = MM_W + CF_W;
    localparam int MIX_W = ACC_W + CF_W + 2;

    logic [BETA_W-1:0]       beta_c;
    logic [BETA_W-1:0]       alpha;
    logic signed [CF_W-1:0]  a_s;
    logic signed [CF_W-1:0]  b_s;
    logic signed [HI_W-1:0]  sum_hi;
    logic signed [LO_W:0]    sum_lo;
    logic signed [MM_W-1:0]  mm;
    logic signed [PHI_W-1:0] n_p_hi;
    logic signed [PLO_W-1:0] n_p_lo;
    logic signed [PMM_W-1:0] n_p_mm;

    // partial products
    logic                    r_m_valid;
    logic signed [PHI_W-1:0] r_p_hi;
    logic signed [PLO_W-1:0] r_p_lo;
    logic signed [PMM_W-1:0] r_p_mm;
    logic [IDX_W-1:0]        r_m_max_idx;
    logic [IDX_W-1:0]        r_m_min_idx;
    logic                    r_m_ovf;

    logic signed [MIX_W-1:0] n_mix;

    logic      r_o_valid;
    t_out_item r_out;

    logic o_stage_ready;
    logic m_ready;

    assign o_stage_ready = !r_o_valid || o_out.ready;
    assign m_ready       = !r_m_valid || o_stage_ready;
    assign o_snap_ready  = m_ready;

    // beta above one counts as one
    assign beta_c = (i_beta > Q15_ONE) ? Q15_ONE : i_beta;
    assign alpha  = Q15_ONE - beta_c;
    assign a_s    = $signed({1'b0, alpha});
    assign b_s    = $signed({1'b0, beta_c});

    // the wide sum is split so that each multiplier stays narrow
    assign sum_hi = $signed(i_snap.sum[ACC_W-1:LO_W]);
    assign sum_lo = $signed({1'b0, i_snap.sum[LO_W-1:0]});
    assign mm     = MM_W'($signed(i_snap.max_prod)) + MM_W'($signed(i_snap.min_prod));

    assign n_p_hi = PHI_W'(sum_hi) * PHI_W'(a_s);
    assign n_p_lo = PLO_W'(sum_lo) * PLO_W'(a_s);
    assign n_p_mm = PMM_W'(mm) * PMM_W'(b_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (m_ready) begin
            r_m_valid <= i_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_ready && i_snap_valid) begin
            r_p_hi      <= n_p_hi;
            r_p_lo      <= n_p_lo;
            r_p_mm      <= n_p_mm;
            r_m_max_idx <= f_idx(i_snap.max_pos);
            r_m_min_idx <= f_idx(i_snap.min_pos);
            r_m_ovf     <= i_snap.ovf;
        end
    end

    assign n_mix = (MIX_W'(r_p_hi) <<< LO_W) + MIX_W'(r_p_lo) + MIX_W'(r_p_mm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_stage_ready) begin
            r_o_valid <= r_m_valid;
        end
    end

    // arithmetic shift right by the fraction width rounds toward minus infinity
    always_ff @(posedge i_clk) begin
        if (o_stage_ready && r_m_valid) begin
            r_out.y_value   <= n_mix[Y_W+FRAC_W-1:FRAC_W];
            r_out.max_index <= r_m_max_idx;
            r_out.min_index <= r_m_min_idx;
            r_out.overflow  <= r_m_ovf;
        end
    end

    assign o_out.valid   = r_o_valid;
    assign o_out.payload = r_out;

endmodule

/* hdl/beta_blend_max_min_neuron_core.sv */
`timescale 1ns / 1ps

// beta-blend max/min neuron: takes one (x, w) pair per clock on i_in, forms
// the 32-bit product and folds it into a saturating 42-bit sum and a
// first-occurrence max/min with positions; the pair marked last closes the
// reduction and produces one item on o_out carrying
// y = ((1-beta)*sum + beta*(max+min)) >>> 15 with both positions and the
// sticky overflow flag (more than MAX_IN pairs). throughput is one pair per
// cycle while i_in.ready is high, set by the multiply and accumulate stage;
// a result passes through the input register, product register, reduction
// snapshot, partial products and output register after its last pair is
// accepted. the blend stages buffer results so pairs of the next reduction
// keep flowing while a result waits; i_in.ready only drops once every stage
// up to the output is full and the consumer is stalling.
// beta lives at byte address 0 of the apb port, resets to 1.0 and is read
// back unclamped; values above 1.0 are treated as 1.0. no clearing pass is
// needed after reset.
module beta_blend_max_min_neuron_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bbmm_in_if.sink                     i_in,
    bbmm_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bbmm_pkg::ADDR_W-1:0] paddr,
    input  logic [bbmm_pkg::DATA_W-1:0] pwdata,
    output logic [bbmm_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import bbmm_pkg::*;

    logic [BETA_W-1:0] beta;
    logic              snap_valid;
    logic              snap_ready;
    t_snap             snap;

    // configuration register
    bbmm_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_beta  (beta)
    );

    // multiply and running reduction, one pair per cycle unless stalled
    bbmm_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap)
    );

    // blend of the finished reduction and output register
    bbmm_blend u_blend (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_snap       (snap),
        .i_beta       (beta),
        .o_out        (o_out)
    );

endmodule

/* hdl/bbmm_checker.sv */
`timescale 1ns / 1ps

module bbmm_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input bbmm_pkg::t_out_item   i_out_payload,
    input logic                  i_pready
);
    import bbmm_pkg::*;

    // nothing leaves the block in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // input only backs up when the output is stalled
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_ready) |-> (i_out_valid && !i_out_ready))
        else $error("input stalled while output free");

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_payload)))
        else $error("result dropped or changed while stalled");

    // apb never inserts wait states
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");

endmodule

bind beta_blend_max_min_neuron_core bbmm_checker u_bbmm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload),
    .i_pready      (pready)
);

/* dv/bbmm_blend_monitor.sv */
`timescale 1ns / 1ps

module bbmm_blend_monitor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  bbmm_pkg::t_in_item          i_in_item,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  bbmm_pkg::t_out_item         i_out_item,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [bbmm_pkg::ADDR_W-1:0] i_paddr,
    input  logic [bbmm_pkg::DATA_W-1:0] i_pwdata,
    output int                          o_failures,
    output int                          o_owed
);
    import bbmm_pkg::*;

    localparam logic signed [63:0] SUM_HI = 64'sd2199023255551;
    localparam logic signed [63:0] SUM_LO = -64'sd2199023255552;

    // shadow of the beta register and of one neuron's reduction
    logic [BETA_W-1:0]        beta_reg;
    logic signed [ACC_W-1:0]  run_sum;
    logic signed [PROD_W-1:0] top_prod;
    logic signed [PROD_W-1:0] low_prod;
    logic [POS_W-1:0]         top_pos;
    logic [POS_W-1:0]         low_pos;
    logic [CNT_W-1:0]         pair_count;
    logic                     too_many;

    t_out_item neuron_results [$];
    int        fail_tally = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_tally = fail_tally + 1;
    endtask

    task automatic clear_reduction();
        run_sum    = '0;
        top_prod   = '0;
        low_prod   = '0;
        top_pos    = '0;
        low_pos    = '0;
        pair_count = '0;
        too_many   = 1'b0;
    endtask

    // fold one pair in; the pair marked last yields the blended neuron output
    task automatic absorb_pair(input t_in_item pair);
        logic signed [PROD_W-1:0] prod;
        logic signed [63:0]       wide_sum;
        logic signed [63:0]       beta_eff;
        logic signed [63:0]       mixed;
        logic [POS_W-1:0]         pos;
        t_out_item                res;
        prod = $signed(pair.x_value) * $signed(pair.w_value);
        if (pair_count >= CNT_W'(MAX_IN)) begin
            too_many = 1'b1;
            pos      = POS_W'(MAX_IN - 1);
        end else begin
            pos        = pair_count[POS_W-1:0];
            pair_count = pair_count + 1'b1;
        end
        if (pos == '0 && !too_many) begin
            top_prod = prod;
            low_prod = prod;
            top_pos  = '0;
            low_pos  = '0;
        end else begin
            if (prod > top_prod) begin
                top_prod = prod;
                top_pos  = pos;
            end
            if (prod < low_prod) begin
                low_prod = prod;
                low_pos  = pos;
            end
        end
        wide_sum = run_sum;
        wide_sum = wide_sum + prod;
        if (wide_sum > SUM_HI)
            wide_sum = SUM_HI;
        if (wide_sum < SUM_LO)
            wide_sum = SUM_LO;
        run_sum = wide_sum[ACC_W-1:0];
        if (pair.last_element) begin
            // beta above one counts as one
            beta_eff = (beta_reg > Q15_ONE) ? Q15_ONE : beta_reg;
            mixed = (64'sd32768 - beta_eff) * wide_sum
                  + beta_eff * (longint'(top_prod) + longint'(low_prod));
            mixed = mixed >>> FRAC_W;
            res.y_value   = mixed[Y_W-1:0];
            res.max_index = IDX_W'(top_pos);
            res.min_index = IDX_W'(low_pos);
            res.overflow  = too_many;
            neuron_results.push_back(res);
            clear_reduction();
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (neuron_results.size() == 0) begin
            report("result with nothing owed, y", longint'($signed(got.y_value)), 0);
        end else begin
            want = neuron_results.pop_front();
            if (got.y_value !== want.y_value)
                report("y_value", longint'($signed(got.y_value)),
                       longint'($signed(want.y_value)));
            if (got.max_index !== want.max_index)
                report("max_index", got.max_index, want.max_index);
            if (got.min_index !== want.min_index)
                report("min_index", got.min_index, want.min_index);
            if (got.overflow !== want.overflow)
                report("overflow", got.overflow, want.overflow);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_reduction();
            beta_reg = Q15_ONE;
            neuron_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr[ADDR_W-1:2] == REG_BETA)
                beta_reg = i_pwdata[BETA_W-1:0];
            if (i_out_valid && i_out_ready)
                check_result(i_out_item);
            if (i_in_valid && i_in_ready)
                absorb_pair(i_in_item);
        end
        o_failures <= fail_tally;
        o_owed     <= neuron_results.size();
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import bbmm_pkg::*;

    localparam int ITEMS_PER_PHASE = 62;   // nine random phases, about 700 pairs in all
    localparam int LONG_HOLD       = 300;  // consumer hold-off that fills the blend stages
    localparam int SETTLE_CYCLES   = 8;    // settle time after the last owed result is out
    localparam int WATCHDOG_LIMIT  = 3000; // far above the hold-off plus the longest gaps

    // unused register slot, writes there must leave beta alone
    localparam logic [RIDX_W-1:0] REG_UNUSED = RIDX_W'(1);

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    bbmm_in_if  in_ch ();
    bbmm_out_if out_ch ();

    bit burst;         // both sides stop idling while set
    bit hold_off_req;  // asks the consumer for one long hold-off
    int quiet_cycles;
    int failures;
    int owed;
    int beta_plan [0:7];

    beta_blend_max_min_neuron_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // watches both channels and the apb port, predicts and compares
    bbmm_blend_monitor u_blend_monitor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_ready  (in_ch.ready),
        .i_in_item   (in_ch.payload),
        .i_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_out_item  (out_ch.payload),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_failures  (failures),
        .o_owed      (owed)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // operand values: corners, tiny values that make ties likely, or anything
    function automatic logic [X_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'hffff;
                    2: return 16'h0000;
                    3: return 16'h0001;
                    default: return 16'h7fff;
                endcase
            end
            1: return X_W'($urandom_range(0, 8) - 4);
            default: return X_W'($urandom);
        endcase
    endfunction

    // offer one item after a random gap and return at the edge that takes it;
    // valid stays high so a following item with no gap goes out back to back
    task automatic push_pair(input logic [X_W-1:0] x, input logic [X_W-1:0] w,
                             input logic last);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= '{x_value: x, w_value: w, last_element: last};
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // one whole neuron: either a run of identical pairs or random pairs
    task automatic run_neuron(input int len, input bit steady,
                              input logic [X_W-1:0] x, input logic [X_W-1:0] w);
        for (int k = 0; k < len; k++)
            push_pair(steady ? x : pick_value(), steady ? w : pick_value(), k == len - 1);
    endtask

    // mostly short neurons, now and then a longer one; bursts come and go
    task automatic random_neurons(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            if ($urandom_range(0, 4) == 0)
                burst = ~burst;
            run_neuron(len, 1'b0, '0, '0);
            sent = sent + len;
        end
    endtask

    // sender pause: drop valid, wait until every owed result is out, then let
    // the pipeline settle so a register write finds the block idle
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (owed != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write: setup cycle, then access cycle held until pready
    task automatic apb_write(input logic [RIDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // consumer: random stall before each result, one long hold-off on request
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            stall = burst ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // watchdog on cycles with nothing moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_rst_n       <= 1'b0;
        burst         = 1'b0;
        hold_off_req  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, beta at its reset value of one
        // single-pair neurons: first pair loads max and min, product corners
        push_pair(16'h7fff, 16'h7fff, 1'b1);
        push_pair(16'h8000, 16'h8000, 1'b1);
        push_pair(16'h8000, 16'h7fff, 1'b1);
        push_pair(16'h0000, 16'h0000, 1'b1);
        // ties on both max and min, first occurrence must win
        push_pair(16'h0001, 16'h0005, 1'b0);
        push_pair(16'h0005, 16'h0001, 1'b0);
        push_pair(16'hfffe, 16'h0003, 1'b0);
        push_pair(16'h0003, 16'hfffe, 1'b0);
        push_pair(16'hffff, 16'h0006, 1'b1);
        // extremes mixed inside one neuron
        push_pair(16'h7fff, 16'h8000, 1'b0);
        push_pair(16'h8000, 16'h8000, 1'b0);
        push_pair(16'h7fff, 16'h7fff, 1'b0);
        push_pair(16'h0000, 16'hffff, 1'b0);
        push_pair(16'hffff, 16'hffff, 1'b1);
        // max moving late, min on the last pair
        push_pair(16'h0001, 16'h0001, 1'b0);
        push_pair(16'h0002, 16'h0002, 1'b0);
        push_pair(16'h0003, 16'h0003, 1'b0);
        push_pair(16'hfffc, 16'h0004, 1'b1);

        random_neurons(ITEMS_PER_PHASE);

        // beta sweep: zero, above one, tiny, half, just under one, one, random up to one, random above one
        beta_plan = '{0, 65535, 1, 16384, 32767, 32768, 0, 0};
        beta_plan[6] = $urandom_range(0, 32768);
        beta_plan[7] = $urandom_range(32769, 65535);
        for (int i = 0; i < 8; i++) begin
            drain();
            // upper data bits are junk, only the low half is the register
            apb_write(REG_BETA, {16'($urandom), 16'(beta_plan[i])});
            if (i == 2)
                apb_write(REG_UNUSED, $urandom);
            random_neurons(ITEMS_PER_PHASE);
            if (i == 3) begin
                // consumer holds off while one- and two-pair neurons keep coming,
                // so the blend stages fill and the input stalls
                drain();
                burst        = 1'b1;
                hold_off_req = 1'b1;
                for (int j = 0; j < 60; j++)
                    run_neuron($urandom_range(1, 2), 1'b0, '0, '0);
                burst = 1'b0;
            end
        end

        drain();
        if (failures == 0 && owed == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
